/* hdl/fta_pkg.sv */
// ----------------------------------------------------------------------------
// fta_pkg: shared types, constants and functions
// Field widths, reset values, membership breakpoints, rule weights and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fta_pkg;

	localparam int LC_W      = 8;
	localparam int THR_W     = 16;
	localparam int LOW_W     = 15;
	localparam int STEP_W    = 10;
	localparam int MF_W      = 16;
	localparam int DEN_W     = 17;
	localparam int NUM_W     = 27;
	localparam int DIV_W     = 26;
	localparam int DIV_CNT_W = 5;
	localparam int PROD_W    = 32;
	localparam int CFG_IDX_W = 1;
	localparam int MF_IDX_W  = 3;
	localparam int FRAC_W    = 15;
	localparam int THIRD_SHIFT = 17;

	localparam logic [THR_W-1:0] MIN_RESET   = 16'd2560;
	localparam logic [THR_W-1:0] MAX_RESET   = 16'd51200;
	localparam logic [THR_W-1:0] UPPER_RESET = 16'd25600;
	localparam logic [MF_W-1:0]  ONE_Q15     = 16'h8000;
	localparam logic [8:0]       STEP_LIMIT  = 9'd384;
	// floor(n / 3) == (n * 43691) >> 17 for every 16-bit n
	localparam logic [THR_W-1:0] THIRD_RECIP = 16'd43691;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX = 1'b1;

	typedef logic [MF_IDX_W-1:0] mf_idx_t;
	localparam mf_idx_t MF_TOO_FEW  = 3'd0;
	localparam mf_idx_t MF_FEW      = 3'd1;
	localparam mf_idx_t MF_GOOD     = 3'd2;
	localparam mf_idx_t MF_MANY     = 3'd3;
	localparam mf_idx_t MF_TOO_MANY = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MF_EVAL,
		ST_MF_DIV,
		ST_MF_ACC,
		ST_AVG_START,
		ST_AVG_DIV,
		ST_UPDATE,
		ST_THIRD,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		logic    load_x;
		mf_idx_t mf_idx;
		logic    mf_direct;
		logic    div_start_mf;
		logic    mf_from_div;
		logic    acc;
		logic    div_start_avg;
		logic    set_adj;
		logic    update;
		logic    calc_third;
		logic    out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic mf_trivial;
		logic div_done;
		logic out_full;
	} ctl_stat_t;

	// Membership term: either saturated (zero or one) or the fraction k / d.
	typedef struct packed {
		logic       zero;
		logic       one;
		logic [3:0] k;
		logic [3:0] d;
	} mf_term_t;

	function automatic mf_term_t tri_term(input logic [LC_W-1:0] x,
			input logic [LC_W-1:0] a, input logic [LC_W-1:0] b,
			input logic [LC_W-1:0] c);
		mf_term_t   t;
		logic [LC_W-1:0] k_lo;
		logic [LC_W-1:0] k_hi;
		logic [LC_W-1:0] d_lo;
		logic [LC_W-1:0] d_hi;
		k_lo   = x - a;
		k_hi   = c - x;
		d_lo   = b - a;
		d_hi   = c - b;
		t.zero = (x <= a) || (x >= c);
		t.one  = (x == b);
		if (x < b) begin
			t.k = k_lo[3:0];
			t.d = d_lo[3:0];
		end else begin
			t.k = k_hi[3:0];
			t.d = d_hi[3:0];
		end
		return t;
	endfunction

	function automatic mf_term_t fall_term(input logic [LC_W-1:0] x,
			input logic [LC_W-1:0] s, input logic [LC_W-1:0] e);
		mf_term_t   t;
		logic [LC_W-1:0] k_v;
		logic [LC_W-1:0] d_v;
		k_v    = e - x;
		d_v    = e - s;
		t.one  = (x <= s);
		t.zero = (x >= e);
		t.k    = k_v[3:0];
		t.d    = d_v[3:0];
		return t;
	endfunction

	function automatic mf_term_t rise_term(input logic [LC_W-1:0] x,
			input logic [LC_W-1:0] s, input logic [LC_W-1:0] e);
		mf_term_t   t;
		logic [LC_W-1:0] k_v;
		logic [LC_W-1:0] d_v;
		k_v    = x - s;
		d_v    = e - s;
		t.zero = (x <= s);
		t.one  = (x >= e);
		t.k    = k_v[3:0];
		t.d    = d_v[3:0];
		return t;
	endfunction

	function automatic mf_term_t mf_term(input mf_idx_t idx, input logic [LC_W-1:0] x);
		mf_term_t t;
		unique case (idx)
			MF_TOO_FEW:  t = fall_term(x, 8'd2, 8'd5);
			MF_FEW:      t = tri_term(x, 8'd3, 8'd6, 8'd10);
			MF_GOOD:     t = tri_term(x, 8'd8, 8'd12, 8'd18);
			MF_MANY:     t = tri_term(x, 8'd15, 8'd20, 8'd28);
			MF_TOO_MANY: t = rise_term(x, 8'd25, 8'd35);
			default:     t = '{zero: 1'b1, one: 1'b0, k: 4'd0, d: 4'd1};
		endcase
		return t;
	endfunction

	// Rule outputs in signed Q.8: -1.5, -0.5, 0, +0.5, +1.5
	function automatic logic signed [STEP_W-1:0] rule_weight(input mf_idx_t idx);
		logic signed [STEP_W-1:0] w;
		unique case (idx)
			MF_TOO_FEW:  w = -10'sd384;
			MF_FEW:      w = -10'sd128;
			MF_GOOD:     w = 10'sd0;
			MF_MANY:     w = 10'sd128;
			MF_TOO_MANY: w = 10'sd384;
			default:     w = 10'sd0;
		endcase
		return w;
	endfunction

endpackage

/* hdl/fta_in_if.sv */
// ----------------------------------------------------------------------------
// fta_in_if: request channel
// Carries one line count per request with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fta_in_if;
	logic                     valid;
	logic                     ready;
	logic [fta_pkg::LC_W-1:0] line_count;

	modport source (output valid, output line_count, input ready);
	modport sink (input valid, input line_count, output ready);
	modport monitor (input valid, input ready, input line_count);
endinterface

/* hdl/fta_out_if.sv */
// ----------------------------------------------------------------------------
// fta_out_if: result channel
// Carries the updated thresholds and the applied step with valid/ready.
// ----------------------------------------------------------------------------
interface fta_out_if;
	logic                              valid;
	logic                              ready;
	logic [fta_pkg::THR_W-1:0]         upper_level;
	logic [fta_pkg::LOW_W-1:0]         lower_level;
	logic signed [fta_pkg::STEP_W-1:0] step_applied;

	modport source (output valid, output upper_level, output lower_level,
		output step_applied, input ready);
	modport sink (input valid, input upper_level, input lower_level,
		input step_applied, output ready);
	modport monitor (input valid, input ready, input upper_level,
		input lower_level, input step_applied);
endinterface

/* hdl/fta_div.sv */
// ----------------------------------------------------------------------------
// fta_div: bit-serial unsigned divider
// Restoring division, one quotient bit per cycle; done pulses for one cycle
// after the last bit, with the quotient held until the next start.
// ----------------------------------------------------------------------------
module fta_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fta_pkg::DIV_W-1:0]   dividend,
	input  logic [fta_pkg::DEN_W-1:0]   divisor,
	output logic [fta_pkg::DIV_W-1:0]   quotient,
	output logic                        done
);

	localparam logic [fta_pkg::DIV_CNT_W-1:0] DIV_LAST =
		fta_pkg::DIV_CNT_W'(fta_pkg::DIV_W - 1);

	logic                           busy_q;
	logic                           done_q;
	logic [fta_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [fta_pkg::DIV_W-1:0]      work_q;
	logic [fta_pkg::DEN_W-1:0]      rem_q;
	logic [fta_pkg::DEN_W-1:0]      div_q;
	logic [fta_pkg::DEN_W:0]        rem_sh;
	logic [fta_pkg::DEN_W:0]        rem_sub;
	logic                           fits;

	always_comb begin
		rem_sh  = {rem_q, work_q[fta_pkg::DIV_W-1]};
		fits    = (rem_sh >= {1'b0, div_q});
		rem_sub = rem_sh - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Quotient bits shift into the dividend register from the bottom.
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			work_q <= {work_q[fta_pkg::DIV_W-2:0], fits};
			rem_q  <= fits ? rem_sub[fta_pkg::DEN_W-1:0] : rem_sh[fta_pkg::DEN_W-1:0];
		end
	end

	assign quotient = work_q;
	assign done     = done_q;

endmodule

/* hdl/fta_dp.sv */
// ----------------------------------------------------------------------------
// fta_dp: datapath
// Membership terms, weighted accumulation, average through the shared
// divider, threshold update and clamp, divide by three, result register.
// ----------------------------------------------------------------------------
module fta_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fta_pkg::ctl_cmd_t               cmd,
	output fta_pkg::ctl_stat_t              stat,
	input  logic                            cfg_we,
	input  logic [fta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fta_pkg::THR_W-1:0]       cfg_data,
	fta_in_if.monitor                       in_ch,
	fta_out_if.source                       out_ch
);

	logic [fta_pkg::LC_W-1:0]          x_q;
	logic [fta_pkg::MF_W-1:0]          m_q;
	logic signed [fta_pkg::NUM_W-1:0]  num_q;
	logic [fta_pkg::DEN_W-1:0]         den_q;
	logic signed [fta_pkg::STEP_W-1:0] adj_q;
	logic [fta_pkg::THR_W-1:0]         upper_q;
	logic [fta_pkg::PROD_W-1:0]        prod_q;
	logic [fta_pkg::THR_W-1:0]         min_q;
	logic [fta_pkg::THR_W-1:0]         max_q;
	logic                              out_valid_q;
	logic [fta_pkg::THR_W-1:0]         out_upper_q;
	logic [fta_pkg::LOW_W-1:0]         out_lower_q;
	logic signed [fta_pkg::STEP_W-1:0] out_step_q;

	fta_pkg::mf_term_t                 term;
	logic signed [fta_pkg::NUM_W-1:0]  weighted;
	logic [fta_pkg::NUM_W-1:0]         num_abs;
	logic                              div_start;
	logic [fta_pkg::DIV_W-1:0]         div_dividend;
	logic [fta_pkg::DEN_W-1:0]         div_divisor;
	logic [fta_pkg::DIV_W-1:0]         div_quot;
	logic                              div_done;
	logic [8:0]                        adj_mag;
	logic [fta_pkg::STEP_W-1:0]        adj_pos;
	logic signed [fta_pkg::STEP_W-1:0] adj_val;
	logic signed [fta_pkg::THR_W+1:0]  next_sum;
	logic signed [fta_pkg::THR_W+1:0]  lo_lim;
	logic signed [fta_pkg::THR_W+1:0]  hi_lim;
	logic signed [fta_pkg::THR_W+1:0]  clamp_lo;
	logic signed [fta_pkg::THR_W+1:0]  clamp_hi;

	always_comb begin
		term     = fta_pkg::mf_term(cmd.mf_idx, x_q);
		weighted = $signed({1'b0, m_q}) * fta_pkg::rule_weight(cmd.mf_idx);
		num_abs  = num_q[fta_pkg::NUM_W-1] ? fta_pkg::NUM_W'(-num_q)
			: fta_pkg::NUM_W'(num_q);

		div_start = cmd.div_start_mf | cmd.div_start_avg;
		if (cmd.div_start_avg) begin
			div_dividend = num_abs[fta_pkg::DIV_W-1:0];
			div_divisor  = den_q;
		end else begin
			div_dividend = fta_pkg::DIV_W'({term.k, {fta_pkg::FRAC_W{1'b0}}});
			div_divisor  = fta_pkg::DEN_W'(term.d);
		end

		// Quotient truncates toward zero: divide magnitudes, restore the sign.
		adj_mag = (div_quot > fta_pkg::DIV_W'(fta_pkg::STEP_LIMIT)) ? fta_pkg::STEP_LIMIT
			: div_quot[8:0];
		adj_pos = {1'b0, adj_mag};
		if (den_q == '0)
			adj_val = '0;
		else if (num_q[fta_pkg::NUM_W-1])
			adj_val = -$signed(adj_pos);
		else
			adj_val = $signed(adj_pos);

		// Lower clamp first, upper clamp second.
		next_sum = $signed({2'b00, upper_q}) + (fta_pkg::THR_W+2)'(adj_q);
		lo_lim   = $signed({2'b00, min_q});
		hi_lim   = $signed({2'b00, max_q});
		clamp_lo = (next_sum < lo_lim) ? lo_lim : next_sum;
		clamp_hi = (clamp_lo > hi_lim) ? hi_lim : clamp_lo;
	end

	fta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= fta_pkg::MIN_RESET;
			max_q       <= fta_pkg::MAX_RESET;
			upper_q     <= fta_pkg::UPPER_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					fta_pkg::CFG_MIN_IDX: min_q <= cfg_data;
					fta_pkg::CFG_MAX_IDX: max_q <= cfg_data;
				endcase
			end
			if (cmd.update)
				upper_q <= clamp_hi[fta_pkg::THR_W-1:0];
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_x) begin
			x_q   <= in_ch.line_count;
			num_q <= '0;
			den_q <= '0;
		end else if (cmd.acc) begin
			num_q <= num_q + weighted;
			den_q <= den_q + fta_pkg::DEN_W'(m_q);
		end
		if (cmd.mf_direct)
			m_q <= term.one ? fta_pkg::ONE_Q15 : '0;
		else if (cmd.mf_from_div)
			m_q <= div_quot[fta_pkg::MF_W-1:0];
		if (cmd.set_adj)
			adj_q <= adj_val;
		if (cmd.calc_third)
			prod_q <= fta_pkg::PROD_W'(upper_q) * fta_pkg::PROD_W'(fta_pkg::THIRD_RECIP);
		if (cmd.out_load) begin
			out_upper_q <= upper_q;
			out_lower_q <= prod_q[fta_pkg::PROD_W-1:fta_pkg::THIRD_SHIFT];
			out_step_q  <= adj_q;
		end
	end

	always_comb begin
		stat.mf_trivial = term.zero | term.one;
		stat.div_done   = div_done;
		stat.out_full   = out_valid_q;
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.upper_level  = out_upper_q;
	assign out_ch.lower_level  = out_lower_q;
	assign out_ch.step_applied = out_step_q;

endmodule

/* hdl/fta_ctrl.sv */
// ----------------------------------------------------------------------------
// fta_ctrl: sequencing state machine
// Steps through the five memberships, the average division, the update and
// the divide by three, then hands the result to the output register.
// ----------------------------------------------------------------------------
module fta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	fta_in_if.sink              in_ch,
	input  fta_pkg::ctl_stat_t  stat,
	output fta_pkg::ctl_cmd_t   cmd
);

	fta_pkg::ctl_state_t state_q;
	fta_pkg::ctl_state_t state_d;
	fta_pkg::mf_idx_t    idx_q;
	logic                accept;

	assign accept = in_ch.valid && (state_q == fta_pkg::ST_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fta_pkg::ST_IDLE:
				if (in_ch.valid) state_d = fta_pkg::ST_MF_EVAL;
			fta_pkg::ST_MF_EVAL:
				state_d = stat.mf_trivial ? fta_pkg::ST_MF_ACC : fta_pkg::ST_MF_DIV;
			fta_pkg::ST_MF_DIV:
				if (stat.div_done) state_d = fta_pkg::ST_MF_ACC;
			fta_pkg::ST_MF_ACC:
				state_d = (idx_q == fta_pkg::MF_TOO_MANY) ? fta_pkg::ST_AVG_START
					: fta_pkg::ST_MF_EVAL;
			fta_pkg::ST_AVG_START:
				state_d = fta_pkg::ST_AVG_DIV;
			fta_pkg::ST_AVG_DIV:
				if (stat.div_done) state_d = fta_pkg::ST_UPDATE;
			fta_pkg::ST_UPDATE:
				state_d = fta_pkg::ST_THIRD;
			fta_pkg::ST_THIRD:
				state_d = fta_pkg::ST_DONE;
			fta_pkg::ST_DONE:
				// hold until the result register is free
				if (!stat.out_full) state_d = fta_pkg::ST_IDLE;
			default:
				state_d = fta_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd               = '0;
		cmd.mf_idx        = idx_q;
		in_ch.ready       = 1'b0;
		unique case (state_q)
			fta_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				cmd.load_x  = in_ch.valid;
			end
			fta_pkg::ST_MF_EVAL: begin
				cmd.mf_direct    = stat.mf_trivial;
				cmd.div_start_mf = !stat.mf_trivial;
			end
			fta_pkg::ST_MF_DIV:
				cmd.mf_from_div = stat.div_done;
			fta_pkg::ST_MF_ACC:
				cmd.acc = 1'b1;
			fta_pkg::ST_AVG_START:
				cmd.div_start_avg = 1'b1;
			fta_pkg::ST_AVG_DIV:
				cmd.set_adj = stat.div_done;
			fta_pkg::ST_UPDATE:
				cmd.update = 1'b1;
			fta_pkg::ST_THIRD:
				cmd.calc_third = 1'b1;
			fta_pkg::ST_DONE:
				cmd.out_load = !stat.out_full;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fta_pkg::ST_IDLE;
			idx_q   <= fta_pkg::MF_TOO_FEW;
		end else begin
			state_q <= state_d;
			if (accept)
				idx_q <= fta_pkg::MF_TOO_FEW;
			else if (state_q == fta_pkg::ST_MF_ACC)
				idx_q <= idx_q + 1'b1;
		end
	end

endmodule

/* hdl/fuzzy_threshold_adjuster.sv */
// ----------------------------------------------------------------------------
// fuzzy_threshold_adjuster: fuzzy update of the upper edge threshold
// Up to two fractional memberships and the average each take the bit-serial divider.
// Next request taken once the result is in the output register, while it waits.
// Async active-low reset: upper 100.0, limits 10.0 and 200.0, no result held.
// ----------------------------------------------------------------------------
module fuzzy_threshold_adjuster (
	input  logic                            clk,
	input  logic                            arst_n,
	fta_in_if                               in_ch,
	fta_out_if                              out_ch,
	input  logic                            cfg_we,
	input  logic [fta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fta_pkg::THR_W-1:0]       cfg_data
);

	fta_pkg::ctl_cmd_t  cmd;
	fta_pkg::ctl_stat_t stat;

	fta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.stat   (stat),
		.cmd    (cmd)
	);

	fta_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

endmodule

/* hdl/fta_checker.sv */
// ----------------------------------------------------------------------------
// fta_checker: port-level checks
// Tracks the limit registers from the write port and checks each result
// against them, the step range, the divide by three and result hold.
// ----------------------------------------------------------------------------
module fta_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	fta_out_if.monitor                      out_ch,
	input  logic                            cfg_we,
	input  logic [fta_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fta_pkg::THR_W-1:0]       cfg_data
);

	logic [fta_pkg::THR_W-1:0] min_sh_q;
	logic [fta_pkg::THR_W-1:0] max_sh_q;
	logic [fta_pkg::THR_W:0]   lower_x3;

	assign lower_x3 = (fta_pkg::THR_W+1)'(out_ch.lower_level) * 17'd3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sh_q <= fta_pkg::MIN_RESET;
			max_sh_q <= fta_pkg::MAX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fta_pkg::CFG_MIN_IDX: min_sh_q <= cfg_data;
				fta_pkg::CFG_MAX_IDX: max_sh_q <= cfg_data;
			endcase
		end
	end

	a_upper_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.upper_level <= max_sh_q) &&
			((min_sh_q > max_sh_q) || (out_ch.upper_level >= min_sh_q)))
		else $error("upper_level outside configured limits");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.step_applied >= -10'sd384) &&
			(out_ch.step_applied <= 10'sd384))
		else $error("step_applied outside -1.5 to +1.5");

	a_lower_third: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (lower_x3 <= {1'b0, out_ch.upper_level}) &&
			(({1'b0, out_ch.upper_level} - lower_x3) < 17'd3))
		else $error("lower_level is not upper_level / 3");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.upper_level) &&
			$stable(out_ch.lower_level) && $stable(out_ch.step_applied))
		else $error("stalled result changed");

endmodule

bind fuzzy_threshold_adjuster fta_checker u_fta_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_ch    (out_ch),
	.cfg_we    (cfg_we),
	.cfg_index (cfg_index),
	.cfg_data  (cfg_data)
);

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for fuzzy_threshold_adjuster
// Sends line counts through the request channel and checks each result
// against a cycle-free model of the membership, averaging and clamping path.
// A short directed table runs first, then runs of random counts under several
// clamp settings. Idling on both channels is random but for the last two phases.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fta_pkg::*;

	localparam int CYCLE_LIMIT  = 1_200_000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 166;
	localparam int DIR_ROWS     = 24;
	localparam int FULL         = int'(ONE_Q15);

	localparam int W_TOO_FEW  = -384;
	localparam int W_FEW      = -128;
	localparam int W_MANY     = 128;
	localparam int W_TOO_MANY = 384;
	localparam int STEP_MAX   = int'(STEP_LIMIT);

	typedef struct packed {
		logic [THR_W-1:0]         upper;
		logic [LOW_W-1:0]         lower;
		logic signed [STEP_W-1:0] step;
	} level_t;

	typedef struct {
		logic [LC_W-1:0] count;
		bit              typed;
		level_t          want;
	} dir_row_t;

	typedef enum int {
		RUN_LOW,
		RUN_MID,
		RUN_HIGH,
		RUN_ANY
	} run_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;

	fta_in_if  in_ch ();
	fta_out_if out_ch ();

	fuzzy_threshold_adjuster dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	level_t           level_q[$];
	logic [THR_W-1:0] model_upper;
	logic [THR_W-1:0] model_min;
	logic [THR_W-1:0] model_max;
	int               send_idle_pct;
	int               recv_idle_pct;
	int               errors;
	int               cycles;

	dir_row_t dir_table[DIR_ROWS] = '{
		'{8'd0,   1'b1, '{16'd25216, 15'd8405, -10'sd384}},
		'{8'd255, 1'b1, '{16'd25600, 15'd8533, 10'sd384}},
		'{8'd12,  1'b1, '{16'd25600, 15'd8533, 10'sd0}},
		'{8'd2,   1'b0, '0},
		'{8'd3,   1'b0, '0},
		'{8'd4,   1'b0, '0},
		'{8'd5,   1'b0, '0},
		'{8'd6,   1'b0, '0},
		'{8'd7,   1'b0, '0},
		'{8'd8,   1'b0, '0},
		'{8'd10,  1'b0, '0},
		'{8'd15,  1'b0, '0},
		'{8'd18,  1'b0, '0},
		'{8'd20,  1'b0, '0},
		'{8'd25,  1'b0, '0},
		'{8'd28,  1'b0, '0},
		'{8'd30,  1'b0, '0},
		'{8'd35,  1'b0, '0},
		'{8'd34,  1'b0, '0},
		'{8'd1,   1'b0, '0},
		'{8'd9,   1'b0, '0},
		'{8'd128, 1'b0, '0},
		'{8'd36,  1'b0, '0},
		'{8'd170, 1'b0, '0}
	};

	logic [THR_W-1:0] phase_min[PHASES] = '{16'd0, 16'd0, 16'd65535, 16'd30000,
		16'd60000, 16'd25000, 16'd0, 16'd2560};
	logic [THR_W-1:0] phase_max[PHASES] = '{16'd65535, 16'd0, 16'd65535, 16'd30000,
		16'd1000, 16'd26000, 16'd0, 16'd51200};

	always #5 clk = ~clk;

	function automatic int ramp_down(input int x, input int s, input int e);
		if (x <= s) return FULL;
		if (x >= e) return 0;
		return ((e - x) * FULL) / (e - s);
	endfunction

	function automatic int ramp_up(input int x, input int s, input int e);
		if (x <= s) return 0;
		if (x >= e) return FULL;
		return ((x - s) * FULL) / (e - s);
	endfunction

	function automatic int triangle(input int x, input int a, input int b, input int c);
		if (x <= a || x >= c) return 0;
		if (x == b) return FULL;
		if (x < b) return ((x - a) * FULL) / (b - a);
		return ((c - x) * FULL) / (c - b);
	endfunction

	// Advance the kept threshold by one frame and return the result it reports.
	function automatic level_t next_level(input logic [LC_W-1:0] count);
		int     x;
		int     m_too_few;
		int     m_few;
		int     m_good;
		int     m_many;
		int     m_too_many;
		int     num;
		int     den;
		int     adj;
		int     nxt;
		level_t r;
		x          = int'(count);
		m_too_few  = ramp_down(x, 2, 5);
		m_few      = triangle(x, 3, 6, 10);
		m_good     = triangle(x, 8, 12, 18);
		m_many     = triangle(x, 15, 20, 28);
		m_too_many = ramp_up(x, 25, 35);
		num = m_too_few * W_TOO_FEW + m_few * W_FEW + m_many * W_MANY
			+ m_too_many * W_TOO_MANY;
		den = m_too_few + m_few + m_good + m_many + m_too_many;
		adj = (den > 0) ? num / den : 0;
		if (adj > STEP_MAX) adj = STEP_MAX;
		if (adj < -STEP_MAX) adj = -STEP_MAX;
		// min first, then max: crossed limits end at max
		nxt = int'(model_upper) + adj;
		if (nxt < int'(model_min)) nxt = int'(model_min);
		if (nxt > int'(model_max)) nxt = int'(model_max);
		model_upper = nxt[THR_W-1:0];
		r.upper = model_upper;
		r.lower = LOW_W'(model_upper / 16'd3);
		r.step  = STEP_W'(adj);
		return r;
	endfunction

	function automatic logic [LC_W-1:0] pick_count(input run_mode_t mode);
		case (mode)
			RUN_LOW:  return LC_W'($urandom_range(0, 5));
			RUN_MID:  return LC_W'($urandom_range(6, 27));
			RUN_HIGH: return LC_W'($urandom_range(28, 255));
			default:  return LC_W'($urandom_range(0, 255));
		endcase
	endfunction

	// Called at a rising edge; returns at the edge where the request is taken.
	task automatic send_count(input logic [LC_W-1:0] count, input bit typed,
			input level_t want);
		level_t lvl;
		if ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid      <= 1'b1;
		in_ch.line_count <= count;
		do @(posedge clk); while (!in_ch.ready);
		lvl = next_level(count);
		level_q.push_back(typed ? want : lvl);
	endtask

	task automatic wait_drained();
		while (level_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_limits(input logic [THR_W-1:0] lo, input logic [THR_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MIN_IDX;
		cfg_data  <= lo;
		@(posedge clk);
		model_min = lo;
		cfg_index <= CFG_MAX_IDX;
		cfg_data  <= hi;
		@(posedge clk);
		model_max = hi;
		cfg_we <= 1'b0;
	endtask

	task automatic take_level();
		level_t got;
		level_t want;
		got.upper = out_ch.upper_level;
		got.lower = out_ch.lower_level;
		got.step  = out_ch.step_applied;
		if (level_q.size() == 0) begin
			$display("%0t: unexpected result upper %0d lower %0d step %0d",
				$time, got.upper, got.lower, got.step);
			errors++;
		end else begin
			want = level_q.pop_front();
			if (got.upper !== want.upper || got.lower !== want.lower
					|| got.step !== want.step) begin
				$display("%0t: expected upper %0d lower %0d step %0d, got upper %0d lower %0d step %0d",
					$time, want.upper, want.lower, want.step,
					got.upper, got.lower, got.step);
				errors++;
			end
		end
	endtask

	// Result side: check on handshake, then pick the next ready.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) take_level();
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		cycles = 0;
		while (cycles <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("fuzzy_threshold_adjuster: mismatch");
		$finish;
	end

	initial begin
		int        left;
		int        len;
		run_mode_t mode;
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_MIN_IDX;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.line_count = '0;
		errors           = 0;
		send_idle_pct    = 37;
		recv_idle_pct    = 74;
		model_upper      = UPPER_RESET;
		model_min        = MIN_RESET;
		model_max        = MAX_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i])
			send_count(dir_table[i].count, dir_table[i].typed, dir_table[i].want);

		for (int p = 0; p < PHASES; p++) begin
			// hold the sender until the block is idle before touching the limits
			in_ch.valid <= 1'b0;
			wait_drained();
			if (p == 6)
				write_limits(THR_W'($urandom), THR_W'($urandom));
			else
				write_limits(phase_min[p], phase_max[p]);
			if (p < 3) begin
				send_idle_pct = 37;
				recv_idle_pct = 74;
			end else if (p < 6) begin
				send_idle_pct = 74;
				recv_idle_pct = 37;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			left = PHASE_ITEMS;
			while (left > 0) begin
				// runs of one kind of count drive the threshold into the clamps
				mode = run_mode_t'($urandom_range(3));
				len  = $urandom_range(1, 40);
				for (int k = 0; k < len && left > 0; k++) begin
					send_count(pick_count(mode), 1'b0, '0);
					left--;
					if ($urandom_range(99) == 0) begin
						in_ch.valid <= 1'b0;
						wait_drained();
					end
				end
			end
		end

		in_ch.valid <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("fuzzy_threshold_adjuster: match");
		else
			$display("fuzzy_threshold_adjuster: mismatch");
		$finish;
	end

endmodule
